FILE: hw/rtl/k_subset_generator_assert.svh
// Assertion macros for the combination generator.
`ifndef K_SUBSET_GENERATOR_ASSERT_SVH
`define K_SUBSET_GENERATOR_ASSERT_SVH

// Checked on every clock edge outside reset.
`define KSG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define KSG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/ksg_pkg.sv
`timescale 1ns / 1ps

package ksg_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int MAX_PICK  = 8;

  localparam int ITEM_W = 32;
  localparam int SET_W  = 5;
  localparam int SUB_W  = 4;
  localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int PW     = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
  localparam int NW     = $clog2(MAX_ITEMS + 1);
  localparam int KW     = $clog2(MAX_PICK + 1);
  localparam int CW     = ((NW > KW) ? NW : KW) + 1;

  // func codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_NEXT = 1'b1;

  // register indexes (byte address / 4)
  localparam logic REG_SET_SIZE    = 1'b0;
  localparam logic REG_SUBSET_SIZE = 1'b1;

  typedef logic signed [ITEM_W-1:0] item_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [PW-1:0]            grow_t;
  typedef logic [NW-1:0]            n_t;
  typedef logic [KW-1:0]            k_t;
  typedef idx_t [MAX_PICK-1:0]      pick_vec_t;

  typedef struct packed {
    logic restart;
    logic advance;
  } idx_ctrl_t;

  typedef struct packed {
    logic                exhausted;
    logic                is_last;
    logic [MAX_PICK-1:0] used;
  } idx_stat_t;

endpackage

FILE: hw/rtl/ksg_bank.sv
`timescale 1ns / 1ps

// One copy of the item store, one write port, one registered read port.
module ksg_bank (
  input  logic           clk_i,
  input  logic           we_i,
  input  ksg_pkg::idx_t  waddr_i,
  input  ksg_pkg::item_t wdata_i,
  input  logic           re_i,
  input  ksg_pkg::idx_t  raddr_i,
  output ksg_pkg::item_t rdata_o
);

  ksg_pkg::item_t mem_q [ksg_pkg::MAX_ITEMS];
  ksg_pkg::item_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ksg_index.sv
`timescale 1ns / 1ps

// Current combination as ascending positions, and its one-step successor.
module ksg_index (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ksg_pkg::n_t         n_i,
  input  ksg_pkg::k_t         k_i,
  input  ksg_pkg::idx_ctrl_t  ctrl_i,
  output ksg_pkg::pick_vec_t  pick_o,
  output ksg_pkg::idx_stat_t  stat_o
);

  ksg_pkg::pick_vec_t            pick_q, pick_d;
  logic                          finished_q, finished_d;
  logic [ksg_pkg::MAX_PICK-1:0]  can_grow;
  logic                          has_grow;
  ksg_pkg::grow_t                grow;
  ksg_pkg::idx_t                 base;
  logic                          exhausted;

  always_comb begin
    exhausted = finished_q || (k_i == '0) ||
                (ksg_pkg::CW'(k_i) > ksg_pkg::CW'(n_i));

    // position i may still grow if it is below n-k+i
    for (int i = 0; i < ksg_pkg::MAX_PICK; i++) begin
      can_grow[i] = (ksg_pkg::CW'(i) < ksg_pkg::CW'(k_i)) &&
                    (ksg_pkg::CW'(pick_q[i]) <
                     ksg_pkg::CW'(n_i) - ksg_pkg::CW'(k_i) + ksg_pkg::CW'(i));
    end

    // rightmost growable position wins
    grow     = '0;
    has_grow = 1'b0;
    for (int i = 0; i < ksg_pkg::MAX_PICK; i++) begin
      if (can_grow[i]) begin
        grow     = ksg_pkg::PW'(i);
        has_grow = 1'b1;
      end
    end
    base = pick_q[grow];

    pick_d     = pick_q;
    finished_d = finished_q;
    if (ctrl_i.restart) begin
      for (int j = 0; j < ksg_pkg::MAX_PICK; j++) begin
        pick_d[j] = ksg_pkg::IDX_W'(j);
      end
      finished_d = 1'b0;
    end else if (ctrl_i.advance && !exhausted) begin
      if (has_grow) begin
        // grown position +1, everything right of it packs up behind
        for (int j = 0; j < ksg_pkg::MAX_PICK; j++) begin
          if (ksg_pkg::PW'(j) >= grow) begin
            pick_d[j] = base + ksg_pkg::IDX_W'(j) - ksg_pkg::IDX_W'(grow) +
                        ksg_pkg::IDX_W'(1);
          end
        end
      end else begin
        finished_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < ksg_pkg::MAX_PICK; j++) begin
        pick_q[j] <= ksg_pkg::IDX_W'(j);
      end
      finished_q <= 1'b0;
    end else begin
      pick_q     <= pick_d;
      finished_q <= finished_d;
    end
  end

  always_comb begin
    stat_o.exhausted = exhausted;
    stat_o.is_last   = !exhausted && !has_grow;
    for (int j = 0; j < ksg_pkg::MAX_PICK; j++) begin
      stat_o.used[j] = !exhausted && (ksg_pkg::CW'(j) < ksg_pkg::CW'(k_i));
    end
  end

  assign pick_o = pick_q;

endmodule

FILE: hw/rtl/k_subset_generator.sv
`timescale 1ns / 1ps
`include "k_subset_generator_assert.svh"

// Lexicographic k-combination generator over up to 16 stored 32-bit items.
// Command channel: an item is taken on a rising edge with start high and
// busy low; busy is tied low, so an item can be taken every cycle.
//  func = load : slot/item_value written to the store, generator restarts,
//                no result.
//  func = next : one result, shown for exactly one cycle with result_strobe
//                high, on the cycle right after the item is taken. Positions
//                at k and above read zero; is_last flags the final
//                combination, exhausted flags a request with none left.
// Throughput 1 item per cycle: the element values come from eight copies
// of the store, each read through its own registered port at the current
// position, while the next positions are formed in the same cycle by a
// parallel search over the eight indices.
// The receiver cannot hold results off; nothing is queued.
// APB port: set_size at 0x0, subset_size at 0x4; a write restarts the
// generator. Reset: set_size 16, subset_size 1, positions 0..7, not
// finished. Stored items are undefined until loaded; no clearing pass.
module k_subset_generator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  func_i,
  input  logic [3:0]            slot_i,
  input  logic signed [31:0]    item_value_i,
  output logic                  result_strobe_o,
  output logic signed [31:0]    elem_0_o,
  output logic signed [31:0]    elem_1_o,
  output logic signed [31:0]    elem_2_o,
  output logic signed [31:0]    elem_3_o,
  output logic signed [31:0]    elem_4_o,
  output logic signed [31:0]    elem_5_o,
  output logic signed [31:0]    elem_6_o,
  output logic signed [31:0]    elem_7_o,
  output logic                  is_last_o,
  output logic                  exhausted_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic                              accept;
  logic                              cfg_wr;
  logic                              load_wr;
  logic                              reg_idx;
  logic [ksg_pkg::SET_W-1:0]         set_size_q;
  logic [ksg_pkg::SUB_W-1:0]         subset_size_q;
  ksg_pkg::n_t                       eff_n;
  ksg_pkg::k_t                       eff_k;
  ksg_pkg::idx_ctrl_t                ctrl;
  ksg_pkg::idx_stat_t                stat;
  ksg_pkg::pick_vec_t                pick;
  ksg_pkg::item_t                    rdata [ksg_pkg::MAX_PICK];
  ksg_pkg::item_t                    elem  [ksg_pkg::MAX_PICK];
  logic                              res_valid_q;
  logic                              is_last_q;
  logic                              exhausted_q;
  logic [ksg_pkg::MAX_PICK-1:0]      used_q;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  // ---- configuration port ----
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q    <= ksg_pkg::SET_W'(16);
      subset_size_q <= ksg_pkg::SUB_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ksg_pkg::REG_SET_SIZE:    set_size_q    <= pwdata[ksg_pkg::SET_W-1:0];
        ksg_pkg::REG_SUBSET_SIZE: subset_size_q <= pwdata[ksg_pkg::SUB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ksg_pkg::REG_SET_SIZE:    prdata = 32'(set_size_q);
      ksg_pkg::REG_SUBSET_SIZE: prdata = 32'(subset_size_q);
      default:                  prdata = '0;
    endcase
  end

  // n and k saturate at the store and output sizes
  always_comb begin
    if (32'(set_size_q) > 32'(ksg_pkg::MAX_ITEMS)) begin
      eff_n = ksg_pkg::NW'(ksg_pkg::MAX_ITEMS);
    end else begin
      eff_n = ksg_pkg::NW'(set_size_q);
    end
    if (32'(subset_size_q) > 32'(ksg_pkg::MAX_PICK)) begin
      eff_k = ksg_pkg::KW'(ksg_pkg::MAX_PICK);
    end else begin
      eff_k = ksg_pkg::KW'(subset_size_q);
    end
  end

  // ---- command decode ----
  assign load_wr = accept && (func_i == ksg_pkg::FUNC_LOAD) &&
                   (32'(slot_i) < 32'(ksg_pkg::MAX_ITEMS));
  assign ctrl.restart = cfg_wr || (accept && (func_i == ksg_pkg::FUNC_LOAD));
  assign ctrl.advance = accept && (func_i == ksg_pkg::FUNC_NEXT);

  ksg_index u_index (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .n_i    (eff_n),
    .k_i    (eff_k),
    .ctrl_i (ctrl),
    .pick_o (pick),
    .stat_o (stat)
  );

  // one store copy per output position, all written together
  for (genvar g = 0; g < ksg_pkg::MAX_PICK; g++) begin : g_bank
    ksg_bank u_bank (
      .clk_i   (clk_i),
      .we_i    (load_wr),
      .waddr_i (ksg_pkg::IDX_W'(slot_i)),
      .wdata_i (item_value_i),
      .re_i    (ctrl.advance),
      .raddr_i (pick[g]),
      .rdata_o (rdata[g])
    );
    assign elem[g] = used_q[g] ? rdata[g] : '0;
  end

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      is_last_q   <= 1'b0;
      exhausted_q <= 1'b0;
      used_q      <= '0;
    end else begin
      res_valid_q <= ctrl.advance;
      if (ctrl.advance) begin
        is_last_q   <= stat.is_last;
        exhausted_q <= stat.exhausted;
        used_q      <= stat.used;
      end
    end
  end

  assign result_strobe_o = res_valid_q;
  assign is_last_o       = is_last_q;
  assign exhausted_o     = exhausted_q;
  assign elem_0_o        = elem[0];
  assign elem_1_o        = elem[1];
  assign elem_2_o        = elem[2];
  assign elem_3_o        = elem[3];
  assign elem_4_o        = elem[4];
  assign elem_5_o        = elem[5];
  assign elem_6_o        = elem[6];
  assign elem_7_o        = elem[7];

  // ---- assertions ----
  `KSG_ASSERT(a_next_gives_result, ctrl.advance |=> result_strobe_o, "next without result")
  `KSG_ASSERT(a_load_no_result, !ctrl.advance |=> !result_strobe_o, "result without next")
  `KSG_ASSERT_ALWAYS(a_last_not_exhausted, !(is_last_q && exhausted_q), "last and exhausted")
  `KSG_ASSERT_ALWAYS(a_exhausted_zero, exhausted_q |-> (used_q == '0), "exhausted with elements")
  `KSG_ASSERT(a_last_then_finished, (result_strobe_o && is_last_o) |-> stat.exhausted, "not finished")

endmodule

FILE: verif/tb_k_subset_generator.sv
`timescale 1ns / 1ps

// Testbench for the k-combination generator.
// Loads and next requests go in on the command port. Every next request is
// predicted here and checked against the strobed result, field by field.
module tb_k_subset_generator;

  // Cycles without any item, result or register write before we give up.
  localparam int QUIET_LIMIT = 1000;
  // Random items after the directed table.
  localparam int RANDOM_ITEMS = 426;
  // Cap on one enumeration run, so wide sets do not dominate the run.
  localparam int RUN_BUDGET = 90;

  // One expected or observed result: eight elements, last flag, exhausted.
  typedef struct packed {
    logic [ksg_pkg::MAX_PICK-1:0][ksg_pkg::ITEM_W-1:0] elems;
    logic                                              is_last;
    logic                                              exhausted;
  } comb_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  // A row of the directed table: an item, or a register write.
  // Where pinned is set, the typed result replaces the predicted one.
  typedef struct {
    row_kind_e      kind;
    logic           func;
    ksg_pkg::idx_t  slot;
    ksg_pkg::item_t value;
    logic           reg_idx;
    logic [31:0]    wdata;
    logic           pinned;
    comb_t          pinned_res;
  } row_t;

  localparam comb_t COMB_NONE = '{elems: '0, is_last: 1'b0, exhausted: 1'b1};

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               func_i;
  logic [3:0]         slot_i;
  logic signed [31:0] item_value_i;
  logic               result_strobe_o;
  logic signed [31:0] elem_0_o, elem_1_o, elem_2_o, elem_3_o;
  logic signed [31:0] elem_4_o, elem_5_o, elem_6_o, elem_7_o;
  logic               is_last_o;
  logic               exhausted_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  k_subset_generator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .slot_i         (slot_i),
    .item_value_i   (item_value_i),
    .result_strobe_o(result_strobe_o),
    .elem_0_o       (elem_0_o),
    .elem_1_o       (elem_1_o),
    .elem_2_o       (elem_2_o),
    .elem_3_o       (elem_3_o),
    .elem_4_o       (elem_4_o),
    .elem_5_o       (elem_5_o),
    .elem_6_o       (elem_6_o),
    .elem_7_o       (elem_7_o),
    .is_last_o      (is_last_o),
    .exhausted_o    (exhausted_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: item store, current positions, finished flag and the
  // two size registers as last written.
  // ---------------------------------------------------------------------
  ksg_pkg::item_t stored_items [ksg_pkg::MAX_ITEMS];
  ksg_pkg::idx_t  pick_pos [ksg_pkg::MAX_PICK];
  logic           gen_done;
  logic [4:0]     set_size_reg = 5'd16;
  logic [3:0]     subset_size_reg = 4'd1;

  comb_t pending_combs [$];        // expected results, oldest first
  logic  pin_valid [32];           // typed results for directed items
  comb_t pin_res [32];

  int errors = 0;
  int items_taken = 0;             // items accepted, counted by the monitor
  int exhausted_seen = 0;          // exhausted results seen
  int sent_items = 0;              // items handed over by the driver
  int idle_pct = 0;                // chance, in percent, of a sender gap
  int quiet_cycles = 0;

  // Positions back to 0..k-1, not finished: after a load or a write.
  function automatic void rewind_picks();
    for (int j = 0; j < ksg_pkg::MAX_PICK; j++) pick_pos[j] = ksg_pkg::idx_t'(j);
    gen_done = 1'b0;
  endfunction

  // Result of a next request; steps the positions on to the following one.
  function automatic comb_t next_combination();
    comb_t res;
    int    n_eff;
    int    k_eff;
    int    grow;
    res = '0;
    n_eff = (set_size_reg > ksg_pkg::MAX_ITEMS) ? ksg_pkg::MAX_ITEMS : int'(set_size_reg);
    k_eff = (subset_size_reg > ksg_pkg::MAX_PICK) ? ksg_pkg::MAX_PICK : int'(subset_size_reg);
    if (gen_done || k_eff == 0 || k_eff > n_eff) begin
      res.exhausted = 1'b1;
      return res;
    end
    for (int j = 0; j < k_eff; j++) res.elems[j] = stored_items[pick_pos[j]];
    // rightmost position that still has room to move up
    grow = -1;
    for (int i = k_eff - 1; i >= 0; i--) begin
      if (grow < 0 && int'(pick_pos[i]) < n_eff - k_eff + i) grow = i;
    end
    if (grow < 0) begin
      gen_done = 1'b1;
      res.is_last = 1'b1;
    end else begin
      pick_pos[grow] = pick_pos[grow] + 1'b1;
      for (int j = grow + 1; j < k_eff; j++) pick_pos[j] = pick_pos[j-1] + 1'b1;
    end
    return res;
  endfunction

  initial begin
    for (int j = 0; j < ksg_pkg::MAX_ITEMS; j++) stored_items[j] = '0;
    for (int j = 0; j < 32; j++) pin_valid[j] = 1'b0;
    rewind_picks();
  end

  // ---------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, before the block's
  // own updates land. The result of the previous item is checked first,
  // then the item taken at this edge is predicted.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    comb_t got;
    comb_t want;
    logic [ksg_pkg::MAX_PICK+1:0] bad;
    if (rst_ni) begin
      if (result_strobe_o) begin
        got.elems = {elem_7_o, elem_6_o, elem_5_o, elem_4_o,
                     elem_3_o, elem_2_o, elem_1_o, elem_0_o};
        got.is_last = is_last_o;
        got.exhausted = exhausted_o;
        if (got.exhausted) exhausted_seen <= exhausted_seen + 1;
        if (pending_combs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, got %h last %b exh %b",
                   $time, got.elems, got.is_last, got.exhausted);
        end else begin
          want = pending_combs.pop_front();
          for (int j = 0; j < ksg_pkg::MAX_PICK; j++)
            bad[j] = (got.elems[j] !== want.elems[j]);
          bad[ksg_pkg::MAX_PICK] = (got.is_last !== want.is_last);
          bad[ksg_pkg::MAX_PICK+1] = (got.exhausted !== want.exhausted);
          if (bad != '0) begin
            errors++;
            $display("%0t: mismatch in fields %b: expected %h last %b exh %b",
                     $time, bad, want.elems, want.is_last, want.exhausted);
            $display("%0t:                   got      %h last %b exh %b",
                     $time, got.elems, got.is_last, got.exhausted);
          end
        end
      end

      // register write: the block is idle here, so order against items
      // does not matter
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == ksg_pkg::REG_SUBSET_SIZE) subset_size_reg = pwdata[3:0];
        else set_size_reg = pwdata[4:0];
        rewind_picks();
      end

      if (start && !busy) begin
        if (func_i == ksg_pkg::FUNC_LOAD) begin
          stored_items[slot_i] = item_value_i;
          rewind_picks();
        end else begin
          want = next_combination();
          if (items_taken < 32 && pin_valid[items_taken]) want = pin_res[items_taken];
          pending_combs.push_back(want);
        end
        items_taken <= items_taken + 1;
      end
    end
  end

  // Watchdog: a run that goes quiet for too long has hung.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe_o || (psel && penable && pwrite))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, nothing moved for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Driver tasks. All are entered and left just after a rising edge.
  // ---------------------------------------------------------------------

  // Hand one item over; returns at the edge that takes it.
  task automatic send_item(input logic f, input ksg_pkg::idx_t s, input ksg_pkg::item_t v);
    start <= 1'b1;
    func_i <= f;
    slot_i <= s;
    item_value_i <= v;
    do @(posedge clk_i); while (busy);
    sent_items++;
  endtask

  // Random sender gap: each cycle is idle at the rate of the current phase.
  task automatic maybe_pause();
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Stop sending, let every expected result drain, then wait out a load that
  // may still be in the pipe.
  task automatic settle();
    start <= 1'b0;
    while (pending_combs.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // APB write: setup, access, then psel low again, after which the register
  // is read back.
  task automatic write_reg(input logic r, input logic [31:0] d);
    logic [31:0] exp_rd;
    exp_rd = (r == ksg_pkg::REG_SUBSET_SIZE) ? (d & 32'h0000_000F) : (d & 32'h0000_001F);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    if (prdata !== exp_rd) begin
      errors++;
      $display("%0t: register read mismatch: expected %h got %h", $time, exp_rd, prdata);
    end
  endtask

  // Load values: the sign, max-positive, all-ones and zero patterns often, else anything.
  function automatic ksg_pkg::item_t pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return ksg_pkg::item_t'($urandom);
    endcase
  endfunction

  function automatic row_t item_row(input logic f, input ksg_pkg::idx_t s,
                                    input ksg_pkg::item_t v);
    row_t r;
    r = '{kind: ROW_ITEM, func: f, slot: s, value: v, reg_idx: 1'b0, wdata: '0,
          pinned: 1'b0, pinned_res: '0};
    return r;
  endfunction

  function automatic row_t write_row(input logic ri, input logic [31:0] d);
    row_t r;
    r = item_row(ksg_pkg::FUNC_LOAD, '0, '0);
    r.kind = ROW_WRITE;
    r.reg_idx = ri;
    r.wdata = d;
    return r;
  endfunction

  function automatic row_t typed_next(input comb_t c);
    row_t r;
    r = item_row(ksg_pkg::FUNC_NEXT, '0, '0);
    r.pinned = 1'b1;
    r.pinned_res = c;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    row_t  dir_rows [$];
    row_t  row;
    comb_t lone;
    int    phase;
    int    random_sent;
    int    exh_mark;
    int    budget;
    int    sel;
    int    n_cfg;
    int    k_cfg;

    rst_ni = 1'b0;
    start = 1'b0;
    func_i = ksg_pkg::FUNC_LOAD;
    slot_i = '0;
    item_value_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    // Directed table.
    // k of zero answers exhausted straight away.
    dir_rows.push_back(write_row(ksg_pkg::REG_SUBSET_SIZE, 32'd0));
    dir_rows.push_back(typed_next(COMB_NONE));
    // n of zero: k is bigger than n, exhausted again
    dir_rows.push_back(write_row(ksg_pkg::REG_SET_SIZE, 32'd0));
    dir_rows.push_back(write_row(ksg_pkg::REG_SUBSET_SIZE, 32'd1));
    dir_rows.push_back(typed_next(COMB_NONE));
    // fill the whole store before anything reads it
    dir_rows.push_back(item_row(ksg_pkg::FUNC_LOAD, 4'd0, 32'h8000_0000));
    dir_rows.push_back(item_row(ksg_pkg::FUNC_LOAD, 4'd1, 32'h7FFF_FFFF));
    dir_rows.push_back(item_row(ksg_pkg::FUNC_LOAD, 4'd2, 32'hFFFF_FFFF));
    dir_rows.push_back(item_row(ksg_pkg::FUNC_LOAD, 4'd3, 32'h0000_0000));
    dir_rows.push_back(item_row(ksg_pkg::FUNC_LOAD, 4'd4, 32'h0000_0001));
    dir_rows.push_back(item_row(ksg_pkg::FUNC_LOAD, 4'd5, 32'hAAAA_AAAA));
    dir_rows.push_back(item_row(ksg_pkg::FUNC_LOAD, 4'd6, 32'h5555_5555));
    for (int s = 7; s < ksg_pkg::MAX_ITEMS; s++)
      dir_rows.push_back(item_row(ksg_pkg::FUNC_LOAD, ksg_pkg::idx_t'(s),
                                  ksg_pkg::item_t'($urandom)));
    // oversize registers saturate to 16 and 8
    dir_rows.push_back(write_row(ksg_pkg::REG_SET_SIZE, 32'd31));
    dir_rows.push_back(write_row(ksg_pkg::REG_SUBSET_SIZE, 32'd15));
    dir_rows.push_back(item_row(ksg_pkg::FUNC_NEXT, 4'hF, 32'hFFFF_FFFF));
    dir_rows.push_back(item_row(ksg_pkg::FUNC_NEXT, 4'h0, 32'h0000_0000));
    // single item, single pick: one combination, then exhausted
    dir_rows.push_back(write_row(ksg_pkg::REG_SET_SIZE, 32'd1));
    dir_rows.push_back(write_row(ksg_pkg::REG_SUBSET_SIZE, 32'd1));
    lone = '{elems: '0, is_last: 1'b1, exhausted: 1'b0};
    lone.elems[0] = 32'h8000_0000;
    dir_rows.push_back(typed_next(lone));
    dir_rows.push_back(typed_next(COMB_NONE));
    // a load restarts the run even after it was exhausted
    dir_rows.push_back(item_row(ksg_pkg::FUNC_LOAD, 4'd0, 32'h7FFF_FFFF));
    lone.elems[0] = 32'h7FFF_FFFF;
    dir_rows.push_back(typed_next(lone));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.reg_idx, row.wdata);
      end else begin
        if (row.pinned) begin
          pin_res[sent_items] = row.pinned_res;
          pin_valid[sent_items] = 1'b1;
        end
        send_item(row.func, row.slot, row.value);
      end
    end

    // Random part: each run sets both sizes, maybe reloads a few items,
    // then walks the combinations until exhausted, with the odd stray load.
    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 79;
        default: idle_pct = 23;
      endcase
      settle();

      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        n_cfg = $urandom_range(0, 31);
        k_cfg = $urandom_range(0, 15);
      end else if (sel < 18) begin
        n_cfg = ksg_pkg::MAX_ITEMS;
        k_cfg = $urandom_range(1, 2);
      end else if (sel < 26) begin
        n_cfg = $urandom_range(ksg_pkg::MAX_PICK, ksg_pkg::MAX_PICK + 2);
        k_cfg = ksg_pkg::MAX_PICK;
      end else begin
        n_cfg = $urandom_range(1, 8);
        k_cfg = $urandom_range(1, (n_cfg < 4) ? n_cfg : 4);
      end
      // upper data bits are junk: only the register width counts
      write_reg(ksg_pkg::REG_SET_SIZE, (32'($urandom) & 32'hFFFF_FFE0) | 32'(n_cfg));
      write_reg(ksg_pkg::REG_SUBSET_SIZE, (32'($urandom) & 32'hFFFF_FFF0) | 32'(k_cfg));

      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          maybe_pause();
          send_item(ksg_pkg::FUNC_LOAD, ksg_pkg::idx_t'($urandom), pick_value());
          random_sent++;
        end
      end

      exh_mark = exhausted_seen;
      budget = RUN_BUDGET;
      while (exhausted_seen == exh_mark && budget > 0 && random_sent < RANDOM_ITEMS) begin
        maybe_pause();
        if ($urandom_range(0, 99) < 4)
          send_item(ksg_pkg::FUNC_LOAD, ksg_pkg::idx_t'($urandom), pick_value());
        else
          send_item(ksg_pkg::FUNC_NEXT, ksg_pkg::idx_t'($urandom),
                    ksg_pkg::item_t'($urandom));
        random_sent++;
        budget--;
      end
      phase++;
    end

    // drain; the watchdog catches a result that never comes
    settle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
